@@ sv/gwd_pkg.sv @@
package gwd_pkg;

   typedef logic [4:0]  day_type;
   typedef logic [3:0]  month_type;
   typedef logic [11:0] year_type;
   typedef logic [2:0]  weekday_type;

   localparam year_type    YEAR_MAX         = 12'd2099;
   localparam year_type    BASE_YEAR        = 12'd1970;
   localparam weekday_type BASE_WEEKDAY     = 3'd3;
   localparam logic [6:0]  BASE_YEAR_MOD100 = 7'd70;
   localparam logic [8:0]  BASE_YEAR_MOD400 = 9'd370;
   localparam logic [6:0]  LAST_MOD100      = 7'd99;
   localparam logic [8:0]  LAST_MOD400      = 9'd399;

   localparam month_type JANUARY  = 4'd1;
   localparam month_type FEBRUARY = 4'd2;
   localparam month_type DECEMBER = 4'd12;
   localparam day_type   FIRST_DAY = 5'd1;
   localparam weekday_type DAYS_PER_WEEK = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_YEARS,
      ST_MONTHS,
      ST_DAYS,
      ST_NEXT,
      ST_MONDAY,
      ST_DONE
   } state_type;

   typedef struct packed {
      day_type   dim;
      day_type   next_day;
      month_type next_month;
      logic      year_carry;
   } step_type;

   function automatic day_type month_length(month_type month, logic leap);
      day_type len;
      case (month)
         4'd2:                           len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:        len = 5'd30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8,
         4'd10, 4'd12:                   len = 5'd31;
         default:                        len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

@@ sv/gwd_step.sv @@
module gwd_step import gwd_pkg::*; (
   input  day_type   day,
   input  month_type month,
   input  logic      leap,
   output step_type  result
);

   always_comb begin
      result.dim        = month_length(month, leap);
      result.next_day   = day + 5'd1;
      result.next_month = month;
      result.year_carry = 1'b0;
      if (day >= result.dim) begin
         result.next_day = FIRST_DAY;
         if (month >= DECEMBER) begin
            result.next_month = JANUARY;
            result.year_carry = 1'b1;
         end else begin
            result.next_month = month + 4'd1;
         end
      end
   end

endmodule

@@ sv/gregorian_weekday_and_next_monday.sv @@
// A year, month or zero day out of range gives its result from the check state once the request
// is accepted; a day past the end of its month gives it after the year and month walks.
// A valid date walks one year per cycle and one month per cycle, then reduces the day sum
// by seven and takes the Monday steps, with all month and Monday steps on one stepper.
// Throughput: one request at a time; the next is accepted in the cycle after the result is taken.
// Reset: synchronous, active high; clears the sequencer and the result valid flag.
module gregorian_weekday_and_next_monday import gwd_pkg::*; #(
   parameter year_type YEAR_LIMIT = YEAR_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  day_type     req_in_day,
   input  month_type   req_in_month,
   input  year_type    req_in_year,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_date_ok,
   output weekday_type rsp_weekday,
   output day_type     rsp_next_day,
   output month_type   rsp_next_month,
   output year_type    rsp_next_year,
   output day_type     rsp_monday_day,
   output month_type   rsp_monday_month,
   output year_type    rsp_monday_year
);

   state_type   state_ff, state_in;
   logic        valid_ff, valid_in;
   day_type     d_ff, d_in;
   month_type   m_ff, m_in;
   year_type    y_ff, y_in;
   year_type    yc_ff, yc_in;
   logic [6:0]  c100_ff, c100_in;
   logic [8:0]  c400_ff, c400_in;
   logic        leap_ff, leap_in;
   weekday_type wd_ff, wd_in;
   logic [5:0]  sum_ff, sum_in;
   month_type   mc_ff, mc_in;
   day_type     md_ff, md_in;
   month_type   mm_ff, mm_in;
   year_type    my_ff, my_in;
   weekday_type cnt_ff, cnt_in;
   logic        ok_ff, ok_in;
   weekday_type owd_ff, owd_in;
   day_type     nd_ff, nd_in;
   month_type   nm_ff, nm_in;
   year_type    ny_ff, ny_in;
   day_type     od_ff, od_in;
   month_type   om_ff, om_in;
   year_type    oy_ff, oy_in;

   day_type     op_day;
   month_type   op_month;
   step_type    step;
   logic        leap_now;
   logic [3:0]  wd_add;

   gwd_step u_step (
      .day    (op_day),
      .month  (op_month),
      .leap   (leap_ff),
      .result (step)
   );

   assign leap_now = (yc_ff[1:0] == 2'b00) && ((c100_ff != 7'd0) || (c400_ff == 9'd0));

   always_comb begin
      op_day   = d_ff;
      op_month = m_ff;
      case (state_ff)
         ST_MONTHS: op_month = mc_ff;
         ST_MONDAY: begin
            op_day   = md_ff;
            op_month = mm_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      m_ff    <= m_in;
      y_ff    <= y_in;
      yc_ff   <= yc_in;
      c100_ff <= c100_in;
      c400_ff <= c400_in;
      leap_ff <= leap_in;
      wd_ff   <= wd_in;
      sum_ff  <= sum_in;
      mc_ff   <= mc_in;
      md_ff   <= md_in;
      mm_ff   <= mm_in;
      my_ff   <= my_in;
      cnt_ff  <= cnt_in;
      ok_ff   <= ok_in;
      owd_ff  <= owd_in;
      nd_ff   <= nd_in;
      nm_ff   <= nm_in;
      ny_ff   <= ny_in;
      od_ff   <= od_in;
      om_ff   <= om_in;
      oy_ff   <= oy_in;
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      d_in     = d_ff;
      m_in     = m_ff;
      y_in     = y_ff;
      yc_in    = yc_ff;
      c100_in  = c100_ff;
      c400_in  = c400_ff;
      leap_in  = leap_ff;
      wd_in    = wd_ff;
      sum_in   = sum_ff;
      mc_in    = mc_ff;
      md_in    = md_ff;
      mm_in    = mm_ff;
      my_in    = my_ff;
      cnt_in   = cnt_ff;
      ok_in    = ok_ff;
      owd_in   = owd_ff;
      nd_in    = nd_ff;
      nm_in    = nm_ff;
      ny_in    = ny_ff;
      od_in    = od_ff;
      om_in    = om_ff;
      oy_in    = oy_ff;
      wd_add   = 4'd0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               d_in     = req_in_day;
               m_in     = req_in_month;
               y_in     = req_in_year;
               yc_in    = BASE_YEAR;
               c100_in  = BASE_YEAR_MOD100;
               c400_in  = BASE_YEAR_MOD400;
               wd_in    = BASE_WEEKDAY;
               leap_in  = 1'b0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((y_ff < BASE_YEAR) || (y_ff > YEAR_LIMIT) || (m_ff < JANUARY) ||
                (m_ff > DECEMBER) || (d_ff == 5'd0)) begin
               ok_in    = 1'b0;
               owd_in   = '0;
               nd_in    = '0;
               nm_in    = '0;
               ny_in    = '0;
               od_in    = '0;
               om_in    = '0;
               oy_in    = '0;
               valid_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_YEARS;
            end
         end
         ST_YEARS: begin
            if (yc_ff == y_ff) begin
               leap_in  = leap_now;
               mc_in    = JANUARY;
               state_in = ST_MONTHS;
            end else begin
               wd_add  = {1'b0, wd_ff} + (leap_now ? 4'd2 : 4'd1);
               wd_in   = (wd_add >= {1'b0, DAYS_PER_WEEK}) ?
                         3'(wd_add - {1'b0, DAYS_PER_WEEK}) : wd_add[2:0];
               yc_in   = yc_ff + 12'd1;
               c100_in = (c100_ff == LAST_MOD100) ? 7'd0 : c100_ff + 7'd1;
               c400_in = (c400_ff == LAST_MOD400) ? 9'd0 : c400_ff + 9'd1;
            end
         end
         ST_MONTHS: begin
            if (mc_ff == m_ff) begin
               if (d_ff > step.dim) begin
                  ok_in    = 1'b0;
                  owd_in   = '0;
                  nd_in    = '0;
                  nm_in    = '0;
                  ny_in    = '0;
                  od_in    = '0;
                  om_in    = '0;
                  oy_in    = '0;
                  valid_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  sum_in   = {3'b000, wd_ff} + {1'b0, d_ff - 5'd1};
                  state_in = ST_DAYS;
               end
            end else begin
               // Month lengths run 28 to 31, so the low two bits give the excess over four weeks.
               wd_add = {1'b0, wd_ff} + {2'b00, step.dim[1:0]};
               wd_in  = (wd_add >= {1'b0, DAYS_PER_WEEK}) ?
                        3'(wd_add - {1'b0, DAYS_PER_WEEK}) : wd_add[2:0];
               mc_in  = mc_ff + 4'd1;
            end
         end
         ST_DAYS: begin
            if (sum_ff >= {3'b000, DAYS_PER_WEEK}) begin
               sum_in = sum_ff - {3'b000, DAYS_PER_WEEK};
            end else begin
               wd_in    = sum_ff[2:0];
               cnt_in   = (sum_ff[2:0] == 3'd0) ? 3'd0 : DAYS_PER_WEEK - sum_ff[2:0];
               md_in    = d_ff;
               mm_in    = m_ff;
               my_in    = y_ff;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            nd_in    = step.next_day;
            nm_in    = step.next_month;
            ny_in    = y_ff + {11'd0, step.year_carry};
            state_in = ST_MONDAY;
         end
         ST_MONDAY: begin
            if (cnt_ff == 3'd0) begin
               ok_in    = 1'b1;
               owd_in   = wd_ff;
               od_in    = md_ff;
               om_in    = mm_ff;
               oy_in    = my_ff;
               valid_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               md_in  = step.next_day;
               mm_in  = step.next_month;
               my_in  = my_ff + {11'd0, step.year_carry};
               cnt_in = cnt_ff - 3'd1;
            end
         end
         ST_DONE: begin
            if (rsp_ready) begin
               valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid        = valid_ff;
   assign rsp_date_ok      = ok_ff;
   assign rsp_weekday      = owd_ff;
   assign rsp_next_day     = nd_ff;
   assign rsp_next_month   = nm_ff;
   assign rsp_next_year    = ny_ff;
   assign rsp_monday_day   = od_ff;
   assign rsp_monday_month = om_ff;
   assign rsp_monday_year  = oy_ff;

endmodule
